@@ sv/der_tlv_header_walker_assert.svh @@
// assertion macros used by the checker file
`ifndef DER_TLV_HEADER_WALKER_ASSERT_SVH
`define DER_TLV_HEADER_WALKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DTH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("der tlv walker assertion failed");

// next-cycle implication, disabled during reset
`define DTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("der tlv walker assertion failed");

`endif

@@ sv/dth_pkg.sv @@
// types, codes and helpers of the der tlv header walker
package dth_pkg;

  typedef enum logic [3:0] {
    PH_IDENT   = 4'b0001,
    PH_LEN1    = 4'b0010,
    PH_LENN    = 4'b0100,
    PH_CONTENT = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_INTEGER = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_LEN_TOO_LONG = 2'd1,
    ERR_INT_TOO_LONG = 2'd2
  } err_e;

  localparam logic [7:0]  ID_INTEGER    = 8'h02;
  localparam int unsigned CONS_BIT      = 5;
  localparam int unsigned LONG_FORM_BIT = 7;
  localparam logic [31:0] INT_MAX_BYTES = 32'd8;
  localparam logic [2:0]  HDR_MIN       = 3'd2;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         tag_class;
    logic               constructed;
    logic [4:0]         tag_number;
    logic [31:0]        content_length;
    logic [2:0]         header_length;
    logic [31:0]        element_offset;
    logic signed [63:0] integer_value;
    err_e               error_code;
    logic               last_of_run;
  } res_t;

  function automatic res_t make_res(kind_e k, logic [7:0] id, logic [31:0] len,
                                    logic [2:0] hl, logic [31:0] off,
                                    logic signed [63:0] ival, err_e err);
    res_t r;
    r.kind           = k;
    r.tag_class      = id[7:6];
    r.constructed    = id[CONS_BIT];
    r.tag_number     = id[4:0];
    r.content_length = len;
    r.header_length  = hl;
    r.element_offset = off;
    r.integer_value  = ival;
    r.error_code     = err;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage

@@ sv/dth_if.sv @@
// valid/ready channel interfaces for the byte input and the result output
interface dth_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface dth_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         tag_class;
  logic               constructed;
  logic [4:0]         tag_number;
  logic [31:0]        content_length;
  logic [2:0]         header_length;
  logic [31:0]        element_offset;
  logic signed [63:0] integer_value;
  logic [1:0]         error_code;
  logic               last_of_run;

  modport source (
    output valid, output kind, output tag_class, output constructed, output tag_number,
    output content_length, output header_length, output element_offset,
    output integer_value, output error_code, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input tag_class, input constructed, input tag_number,
    input content_length, input header_length, input element_offset,
    input integer_value, input error_code, input last_of_run, output ready
  );
endinterface

@@ sv/dth_res_fifo.sv @@
// result queue taking up to two results per cycle and giving one
module dth_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  dth_pkg::res_t push0_i,
  input  dth_pkg::res_t push1_i,
  input  logic          pop_i,
  output dth_pkg::res_t head_o,
  output logic          valid_o,
  output logic          room_o
);
  import dth_pkg::*;

  res_t                 entries_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic [RES_PTR_W-1:0] wr_next;

  assign wr_next = wr_q + 1'b1;
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign head_o  = entries_q[rd_q];

  always_comb begin
    wr_d    = wr_q + RES_PTR_W'(push_cnt_i);
    rd_d    = pop_i ? rd_q + 1'b1 : rd_q;
    count_d = count_q + RES_CNT_W'(push_cnt_i) - RES_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entries_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      entries_q[wr_next] <= push1_i;
    end
  end

endmodule

@@ sv/der_tlv_header_walker.sv @@
// Streaming DER TLV header walker. One byte is accepted per clock cycle while the input is
// ready; each byte is decoded in the cycle it is accepted and its results (none, one or two)
// enter a four-entry result queue, which drives the output from its head. The input is ready
// whenever the queue has two free entries, which sustains one byte per cycle as long as the
// sink takes results as fast as they come; the second result of a byte that yields two results
// (a header followed by an integer or an error) waits in the queue. Restart marks the first
// byte of a new buffer and clears the offset and the decode state before that byte.
module der_tlv_header_walker #(
  parameter int unsigned MAX_LEN_BYTES = 4,
  parameter int unsigned OFFSET_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dth_in_if.sink    in_i,
  dth_out_if.source out_o
);
  import dth_pkg::*;

  localparam int unsigned LeftW = $clog2(MAX_LEN_BYTES + 1);

  phase_e                  phase_q, phase_d, phase_s;
  logic [7:0]              ident_q, ident_d;
  logic [31:0]             len_acc_q, len_acc_d;
  logic [LeftW-1:0]        len_left_q, len_left_d;
  logic [31:0]             cont_left_q, cont_left_d;
  logic [63:0]             int_acc_q, int_acc_d;
  logic [OFFSET_WIDTH-1:0] byte_off_q, byte_off_d;
  logic [OFFSET_WIDTH-1:0] elem_start_q, elem_start_d;
  logic [2:0]              hdr_len_q, hdr_len_d;

  logic        accept;
  logic [7:0]  byte_in;
  logic [6:0]  cnt;
  logic        fin, err_len, int_done, short_int;
  logic [31:0] off32;
  logic [1:0]  push_cnt;
  res_t        res0, res1, head;
  logic        fifo_valid, fifo_room, pop;

  assign accept  = in_i.valid && in_i.ready;
  assign byte_in = in_i.data_byte;
  assign cnt     = byte_in[6:0];
  assign phase_s = in_i.restart ? PH_IDENT : phase_q;

  always_comb begin
    ident_d      = ident_q;
    len_acc_d    = len_acc_q;
    len_left_d   = len_left_q;
    cont_left_d  = cont_left_q;
    int_acc_d    = int_acc_q;
    byte_off_d   = byte_off_q;
    elem_start_d = elem_start_q;
    hdr_len_d    = hdr_len_q;
    phase_d      = phase_s;
    fin          = 1'b0;
    err_len      = 1'b0;
    int_done     = 1'b0;
    short_int    = 1'b0;
    if (in_i.restart) begin
      ident_d      = '0;
      len_acc_d    = '0;
      len_left_d   = '0;
      cont_left_d  = '0;
      int_acc_d    = '0;
      byte_off_d   = '0;
      elem_start_d = '0;
      hdr_len_d    = '0;
    end

    unique case (phase_s)
      PH_IDENT: begin
        ident_d      = byte_in;
        elem_start_d = byte_off_d;
        len_acc_d    = '0;
        phase_d      = PH_LEN1;
      end
      PH_LEN1: begin
        if (!byte_in[LONG_FORM_BIT]) begin
          len_acc_d = 32'(byte_in);
          hdr_len_d = HDR_MIN;
          fin       = 1'b1;
        end else if (32'(cnt) > MAX_LEN_BYTES) begin
          err_len = 1'b1;
          phase_d = PH_IDENT;
        end else begin
          hdr_len_d = HDR_MIN + cnt[2:0];
          len_acc_d = '0;
          if (cnt == '0) begin
            fin = 1'b1;
          end else begin
            len_left_d = LeftW'(cnt);
            phase_d    = PH_LENN;
          end
        end
      end
      PH_LENN: begin
        len_acc_d = {len_acc_d[23:0], byte_in};
        if (len_left_d != '0) begin
          len_left_d = len_left_d - 1'b1;
        end
        if (len_left_d == '0) begin
          fin = 1'b1;
        end
      end
      PH_CONTENT: begin
        short_int = (ident_d == ID_INTEGER) && (len_acc_d <= INT_MAX_BYTES);
        if (short_int) begin
          int_acc_d = {((cont_left_d == len_acc_d) ? {56{byte_in[7]}} : int_acc_d[55:0]),
                       byte_in};
        end
        if (cont_left_d != '0) begin
          cont_left_d = cont_left_d - 1'b1;
        end
        if (cont_left_d == '0) begin
          int_done = short_int;
          phase_d  = PH_IDENT;
        end
      end
      default: begin
        phase_d = PH_IDENT;
      end
    endcase

    byte_off_d = byte_off_d + 1'b1;
  end

  assign off32 = 32'(elem_start_d);

  always_comb begin
    push_cnt = 2'd0;
    res0 = make_res(KIND_HEADER, ident_d, len_acc_d, hdr_len_d, off32, '0, ERR_NONE);
    res1 = res0;
    if (fin) begin
      push_cnt = 2'd1;
      if (ident_d == ID_INTEGER) begin
        if (len_acc_d > INT_MAX_BYTES) begin
          res1 = make_res(KIND_ERROR, ident_d, len_acc_d, hdr_len_d, off32, '0,
                          ERR_INT_TOO_LONG);
          push_cnt = 2'd2;
        end else if (len_acc_d == '0) begin
          res1 = make_res(KIND_INTEGER, ident_d, '0, hdr_len_d, off32, '0, ERR_NONE);
          push_cnt = 2'd2;
        end
      end
    end else if (err_len) begin
      res0 = make_res(KIND_ERROR, ident_d, '0, '0, off32, '0, ERR_LEN_TOO_LONG);
      push_cnt = 2'd1;
    end else if (int_done) begin
      res0 = make_res(KIND_INTEGER, ident_d, len_acc_d, hdr_len_d, off32,
                      $signed(int_acc_d), ERR_NONE);
      push_cnt = 2'd1;
    end
    if (push_cnt == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
    if (push_cnt == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
    if (!accept) begin
      push_cnt = 2'd0;
    end
  end

  // header completion decides whether content is walked or skipped
  logic        enter_content;
  assign enter_content = fin && !ident_d[CONS_BIT] && (len_acc_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDENT;
      ident_q      <= '0;
      len_acc_q    <= '0;
      len_left_q   <= '0;
      cont_left_q  <= '0;
      int_acc_q    <= '0;
      byte_off_q   <= '0;
      elem_start_q <= '0;
      hdr_len_q    <= '0;
    end else if (accept) begin
      ident_q      <= ident_d;
      len_acc_q    <= len_acc_d;
      len_left_q   <= len_left_d;
      byte_off_q   <= byte_off_d;
      elem_start_q <= elem_start_d;
      hdr_len_q    <= hdr_len_d;
      if (fin) begin
        phase_q <= enter_content ? PH_CONTENT : PH_IDENT;
      end else begin
        phase_q <= phase_d;
      end
      if (enter_content) begin
        cont_left_q <= len_acc_d;
        int_acc_q   <= '0;
      end else begin
        cont_left_q <= cont_left_d;
        int_acc_q   <= int_acc_d;
      end
    end
  end

  assign pop = out_o.valid && out_o.ready;

  dth_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (fifo_valid),
    .room_o     (fifo_room)
  );

  assign in_i.ready           = fifo_room;
  assign out_o.valid          = fifo_valid;
  assign out_o.kind           = head.kind;
  assign out_o.tag_class      = head.tag_class;
  assign out_o.constructed    = head.constructed;
  assign out_o.tag_number     = head.tag_number;
  assign out_o.content_length = head.content_length;
  assign out_o.header_length  = head.header_length;
  assign out_o.element_offset = head.element_offset;
  assign out_o.integer_value  = head.integer_value;
  assign out_o.error_code     = head.error_code;
  assign out_o.last_of_run    = head.last_of_run;

endmodule

@@ sv/dth_checker.sv @@
// port-level checks of the der tlv header walker and their bind
`include "der_tlv_header_walker_assert.svh"

module dth_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         kind_i,
  input logic [31:0]        content_length_i,
  input logic [31:0]        element_offset_i,
  input logic signed [63:0] integer_value_i,
  input logic [1:0]         error_code_i
);
  import dth_pkg::*;

  logic stalled;
  assign stalled = out_valid_i && !out_ready_i;

  `DTH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i && $stable(kind_i) && $stable(content_length_i) && $stable(element_offset_i) && $stable(integer_value_i))
  `DTH_ASSERT_NOW(a_kind_known, clk_i, rst_ni, out_valid_i, kind_i == KIND_HEADER || kind_i == KIND_INTEGER || kind_i == KIND_ERROR)
  `DTH_ASSERT_NOW(a_err_matches_kind, clk_i, rst_ni, out_valid_i, (kind_i == KIND_ERROR) == (error_code_i != ERR_NONE))
  `DTH_ASSERT_NOW(a_value_only_int, clk_i, rst_ni, out_valid_i && kind_i != KIND_INTEGER, integer_value_i == '0)

endmodule

bind der_tlv_header_walker dth_checker u_dth_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .kind_i           (out_o.kind),
  .content_length_i (out_o.content_length),
  .element_offset_i (out_o.element_offset),
  .integer_value_i  (out_o.integer_value),
  .error_code_i     (out_o.error_code)
);

@@ sim/tb.sv @@
// testbench for der_tlv_header_walker: directed and random DER byte streams checked per result
`timescale 1ns / 1ps

module tb;
  import dth_pkg::*;

  localparam int unsigned MAX_LEN     = 4;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned MAX_PRINTS  = 100;

  class tlv_walk_board;
    phase_e             ph;
    logic [7:0]         ident;
    logic [31:0]        len_acc;
    int unsigned        len_left;
    logic [31:0]        content_left;
    logic [63:0]        int_acc;
    logic [OFF_W-1:0]   byte_off;
    logic [OFF_W-1:0]   elem_start;
    logic [2:0]         hdr_len;
    res_t               expected_results[$];
    int                 errors;
    int                 results_seen;

    function new();
      clear_state();
      errors = 0;
      results_seen = 0;
    endfunction

    function void clear_state();
      ph           = PH_IDENT;
      ident        = '0;
      len_acc      = '0;
      len_left     = 0;
      content_left = '0;
      int_acc      = '0;
      byte_off     = '0;
      elem_start   = '0;
      hdr_len      = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void push_result(kind_e k, logic [31:0] len, logic [2:0] hl,
                              logic signed [63:0] iv, err_e e);
      res_t r;
      r.kind           = k;
      r.tag_class      = ident[7:6];
      r.constructed    = ident[CONS_BIT];
      r.tag_number     = ident[4:0];
      r.content_length = len;
      r.header_length  = hl;
      r.element_offset = elem_start[31:0];
      r.integer_value  = iv;
      r.error_code     = e;
      r.last_of_run    = 1'b0;
      expected_results.push_back(r);
    endfunction

    function bit short_integer();
      return ident == ID_INTEGER && len_acc <= INT_MAX_BYTES;
    endfunction

    function void close_header();
      push_result(KIND_HEADER, len_acc, hdr_len, '0, ERR_NONE);
      if (ident == ID_INTEGER) begin
        if (len_acc > INT_MAX_BYTES) begin
          push_result(KIND_ERROR, len_acc, hdr_len, '0, ERR_INT_TOO_LONG);
        end else if (len_acc == 0) begin
          push_result(KIND_INTEGER, '0, hdr_len, '0, ERR_NONE);
        end
      end
      if (ident[CONS_BIT] || len_acc == 0) begin
        ph = PH_IDENT;
      end else begin
        ph           = PH_CONTENT;
        content_left = len_acc;
        int_acc      = '0;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic rs);
      int          first;
      int unsigned cnt;
      first = expected_results.size();
      if (rs) clear_state();
      case (ph)
        PH_IDENT: begin
          ident      = b;
          elem_start = byte_off;
          len_acc    = '0;
          ph         = PH_LEN1;
        end
        PH_LEN1: begin
          if (!b[LONG_FORM_BIT]) begin
            len_acc = {24'd0, b};
            hdr_len = HDR_MIN;
            close_header();
          end else begin
            cnt = 32'(b[6:0]);
            if (cnt > MAX_LEN) begin
              push_result(KIND_ERROR, '0, '0, '0, ERR_LEN_TOO_LONG);
              ph = PH_IDENT;
            end else begin
              hdr_len = HDR_MIN + 3'(cnt);
              len_acc = '0;
              if (cnt == 0) begin
                close_header();
              end else begin
                len_left = cnt;
                ph       = PH_LENN;
              end
            end
          end
        end
        PH_LENN: begin
          len_acc = {len_acc[23:0], b};
          if (len_left > 0) len_left--;
          if (len_left == 0) close_header();
        end
        default: begin
          if (short_integer()) begin
            if (content_left == len_acc) int_acc = b[7] ? '1 : '0;
            int_acc = {int_acc[55:0], b};
          end
          if (content_left != 0) content_left--;
          if (content_left == 0) begin
            if (short_integer()) push_result(KIND_INTEGER, len_acc, hdr_len, int_acc, ERR_NONE);
            ph = PH_IDENT;
          end
        end
      endcase
      byte_off = byte_off + 1'b1;
      if (expected_results.size() > first)
        expected_results[expected_results.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string what, logic [63:0] got_v, logic [63:0] want_v);
      if (errors < MAX_PRINTS)
        $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got_v, want_v);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected result kind", 64'(got.kind), '0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
        if (got.tag_class !== want.tag_class)
          report("tag_class", 64'(got.tag_class), 64'(want.tag_class));
        if (got.constructed !== want.constructed)
          report("constructed", 64'(got.constructed), 64'(want.constructed));
        if (got.tag_number !== want.tag_number)
          report("tag_number", 64'(got.tag_number), 64'(want.tag_number));
        if (got.content_length !== want.content_length)
          report("content_length", 64'(got.content_length), 64'(want.content_length));
        if (got.header_length !== want.header_length)
          report("header_length", 64'(got.header_length), 64'(want.header_length));
        if (got.element_offset !== want.element_offset)
          report("element_offset", 64'(got.element_offset), 64'(want.element_offset));
        if (got.integer_value !== want.integer_value)
          report("integer_value", got.integer_value, want.integer_value);
        if (got.error_code !== want.error_code)
          report("error_code", 64'(got.error_code), 64'(want.error_code));
        if (got.last_of_run !== want.last_of_run)
          report("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   bytes_sent;
  bit   hold_req;
  bit   need_restart;

  tlv_walk_board walker = new();

  dth_in_if  in_ch();
  dth_out_if out_ch();

  der_tlv_header_walker #(
    .MAX_LEN_BYTES(MAX_LEN),
    .OFFSET_WIDTH (OFF_W)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart   <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    walker.note_byte(b, rs);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_len(input logic [31:0] len);
    int nmin;
    int n;
    int i;
    if (len < 128 && $urandom_range(3) != 0) begin
      send_byte(len[7:0], 1'b0);
    end else begin
      nmin = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 :
             (len == 0) ? 0 : 1;
      n = $urandom_range(MAX_LEN, nmin);
      send_byte(8'h80 | 8'(n), 1'b0);
      for (i = n - 1; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0);
    end
  endtask

  task automatic send_element(input logic [7:0] id, input logic rs, input logic [31:0] len,
                              input int unsigned body);
    send_byte(id, rs);
    send_len(len);
    repeat (body) send_byte(pick_byte(), 1'b0);
  endtask

  task automatic gen_record();
    int          sel;
    int unsigned n;
    logic [7:0]  id;
    logic        rs;
    rs = need_restart || ($urandom_range(31) == 0);
    need_restart = 1'b0;
    sel = $urandom_range(99);
    id  = 8'($urandom_range(255));
    if (sel < 40) begin
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
      send_element(ID_INTEGER, rs, n, n);
    end else if (sel < 58) begin
      id[CONS_BIT] = 1'b0;
      if (id == ID_INTEGER) id = 8'h04;
      n = $urandom_range(6);
      send_element(id, rs, n, n);
    end else if (sel < 70) begin
      id[CONS_BIT] = 1'b1;
      send_element(id, rs, $urandom_range(40), 0);
    end else if (sel < 77) begin
      n = $urandom_range(12, 9);
      send_element(ID_INTEGER, rs, n, n);
    end else if (sel < 82) begin
      send_byte(id, rs);
      send_byte(8'h80 | 8'($urandom_range(127, MAX_LEN + 1)), 1'b0);
    end else if (sel < 86) begin
      id[CONS_BIT] = 1'b0;
      send_element(id, rs, $urandom | 32'h0100_0000, $urandom_range(5));
      need_restart = 1'b1;
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(pick_byte(), $urandom_range(7) == 0);
      need_restart = 1'($urandom_range(1));
    end
  endtask

  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    while (walker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind           = kind_e'(out_ch.kind);
      got.tag_class      = out_ch.tag_class;
      got.constructed    = out_ch.constructed;
      got.tag_number     = out_ch.tag_number;
      got.content_length = out_ch.content_length;
      got.header_length  = out_ch.header_length;
      got.element_offset = out_ch.element_offset;
      got.integer_value  = out_ch.integer_value;
      got.error_code     = err_e'(out_ch.error_code);
      got.last_of_run    = out_ch.last_of_run;
      walker.check_result(got);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.restart   = 1'b0;
    rst_n           = 1'b0;
    bytes_sent      = 0;
    hold_req        = 1'b0;
    need_restart    = 1'b0;
    src_idle_pct    = 35;
    snk_idle_pct    = 82;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // negative one-byte integer, then zero-length integer
    send_byte(ID_INTEGER, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(ID_INTEGER, 1'b0);
    send_byte(8'h00, 1'b0);
    // constructed with long form of zero bytes
    send_byte(8'h30, 1'b0);
    send_byte(8'h80, 1'b0);
    // all identifier bits set, length field far too long
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // integer too long through a four-byte length
    send_byte(ID_INTEGER, 1'b0);
    send_byte(8'h84, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    // restart inside skipped content, largest short length
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    // maximum content length
    send_byte(8'hC4, 1'b1);
    send_byte(8'h84, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // largest positive one-byte integer
    send_byte(ID_INTEGER, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);

    while (bytes_sent < 560) gen_record();
    drain_pause();
    src_idle_pct = 82;
    snk_idle_pct = 35;
    while (bytes_sent < 1110) gen_record();
    drain_pause();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (bytes_sent < 1300) gen_record();
    hold_req = 1'b1;
    while (bytes_sent < 1650) gen_record();

    in_ch.valid <= 1'b0;
    while (walker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (walker.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
